/* design/segment_intersection_unit_defines.svh */
// assertion macros for the segment intersection unit
`ifndef SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SIU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SIU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SIU_ASSERT_SAME(label, clk, rst, ante, cons)
`define SIU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/siu_pkg.sv */
// ----------------------------------------------------------------------------
// siu_pkg
// constants shared by the segment intersection unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package siu_pkg;
   localparam int T_FRAC = 30;   // fraction bits of the parameter t
   localparam int MUL_LAT = 2;   // latency of the split multiplier
endpackage
`default_nettype wire

/* design/siu_mul.sv */
// ----------------------------------------------------------------------------
// siu_mul
// signed multiplier split into four partial products, two register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module siu_mul #(
   parameter int A_BITS = 33,
   parameter int B_BITS = 33
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic signed [A_BITS-1:0]         a,
   input  wire logic signed [B_BITS-1:0]         b,
   output logic signed [A_BITS+B_BITS-1:0]       p
);
   import siu_pkg::*;
   localparam int AL = A_BITS / 2;
   localparam int AH = A_BITS - AL;
   localparam int BL = B_BITS / 2;
   localparam int BH = B_BITS - BL;
   localparam int PW = A_BITS + B_BITS;

   logic        [AL-1:0]      al;
   logic signed [AH-1:0]      ah;
   logic        [BL-1:0]      bl;
   logic signed [BH-1:0]      bh;
   logic        [AL+BL-1:0]   ll_ff;
   logic signed [AL+BH:0]     lh_ff;
   logic signed [AH+BL:0]     hl_ff;
   logic signed [AH+BH-1:0]   hh_ff;
   logic signed [PW-1:0]      p_in;
   logic signed [PW-1:0]      p_ff;

   assign al = a[AL-1:0];
   assign ah = a[A_BITS-1:AL];
   assign bl = b[BL-1:0];
   assign bh = b[B_BITS-1:BL];

   // low of a times high of b is shifted by the width of the low half of b
   always_comb begin
      p_in = (PW'(hh_ff) <<< (AL + BL)) + (PW'(lh_ff) <<< BL)
           + (PW'(hl_ff) <<< AL) + $signed(PW'(ll_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= al * bl;
         lh_ff <= $signed({1'b0, al}) * bh;
         hl_ff <= ah * $signed({1'b0, bl});
         hh_ff <= ah * bh;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

/* design/segment_intersection_unit.sv */
// ----------------------------------------------------------------------------
// segment_intersection_unit
// exact intersection test of two fixed-point segments with crossing point
// ----------------------------------------------------------------------------
// Fully pipelined: one segment pair is accepted every cycle while the result
// port is not stalled. The depth comes chiefly from the one-bit-per-stage
// restoring divider that forms t (31 stages) plus the split multipliers for
// the cross products and the point. A stalled result port holds the whole
// pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_unit_defines.svh"
module segment_intersection_unit #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_a_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_y,
   input  wire logic signed [COORD_BITS-1:0] req_c_x,
   input  wire logic signed [COORD_BITS-1:0] req_c_y,
   input  wire logic signed [COORD_BITS-1:0] req_d_x,
   input  wire logic signed [COORD_BITS-1:0] req_d_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_hit,
   output logic signed [COORD_BITS-1:0]      rsp_cross_x,
   output logic signed [COORD_BITS-1:0]      rsp_cross_y
);
   import siu_pkg::*;
   localparam int W   = COORD_BITS;
   localparam int N   = W + 1;
   localparam int P   = 2 * N;
   localparam int D   = P + 1;
   localparam int TA  = T_FRAC + 2;
   localparam int PP  = TA + N;
   localparam int LAT = 1 + MUL_LAT + 1 + 1 + (T_FRAC + 1) + MUL_LAT + 1;

   logic           en;
   logic [LAT-1:0] v_ff;

   // stage 0: edge vectors
   logic signed [N-1:0] s1x_ff, s1y_ff, s2x_ff, s2y_ff, acx_ff, acy_ff;
   logic signed [W-1:0] ax0_ff, ay0_ff;

   // carries through the cross-product multiplier and stage 3
   logic signed [N-1:0] cs1x_ff [0:MUL_LAT];
   logic signed [N-1:0] cs1y_ff [0:MUL_LAT];
   logic signed [W-1:0] cax_ff  [0:MUL_LAT];
   logic signed [W-1:0] cay_ff  [0:MUL_LAT];

   logic signed [P-1:0] m_den1, m_den2, m_sn1, m_sn2, m_tn1, m_tn2;
   logic signed [D-1:0] den_ff, sn_ff, tn_ff;

   // stage 4 onward: divider pipeline, index 0 is the prepared operand
   logic        [D-1:0]        dr_ff  [0:T_FRAC+1];
   logic        [D-1:0]        dd_ff  [0:T_FRAC+1];
   logic        [T_FRAC:0]     dq_ff  [0:T_FRAC+1];
   logic                       dok_ff [0:T_FRAC+1];
   logic signed [N-1:0]        ds1x_ff[0:T_FRAC+1];
   logic signed [N-1:0]        ds1y_ff[0:T_FRAC+1];
   logic signed [W-1:0]        dax_ff [0:T_FRAC+1];
   logic signed [W-1:0]        day_ff [0:T_FRAC+1];

   logic signed [D-1:0] dabs_in, sadj_in, tadj_in;
   logic                ok_in;

   logic                ok_ff [0:MUL_LAT-1];
   logic signed [W-1:0] pax_ff[0:MUL_LAT-1];
   logic signed [W-1:0] pay_ff[0:MUL_LAT-1];
   logic signed [PP-1:0] m_px, m_py;
   logic signed [TA-1:0] t_val;

   logic                hit_ff;
   logic signed [W-1:0] cx_ff, cy_ff;

   assign en        = !v_ff[LAT-1] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1x_ff <= N'(req_b_x) - N'(req_a_x);
         s1y_ff <= N'(req_b_y) - N'(req_a_y);
         s2x_ff <= N'(req_d_x) - N'(req_c_x);
         s2y_ff <= N'(req_d_y) - N'(req_c_y);
         acx_ff <= N'(req_a_x) - N'(req_c_x);
         acy_ff <= N'(req_a_y) - N'(req_c_y);
         ax0_ff <= req_a_x;
         ay0_ff <= req_a_y;
      end
   end

   siu_mul #(.A_BITS(N), .B_BITS(N)) u_den1 (.clock, .en, .a(s1x_ff), .b(s2y_ff), .p(m_den1));
   siu_mul #(.A_BITS(N), .B_BITS(N)) u_den2 (.clock, .en, .a(s2x_ff), .b(s1y_ff), .p(m_den2));
   siu_mul #(.A_BITS(N), .B_BITS(N)) u_sn1  (.clock, .en, .a(s1x_ff), .b(acy_ff), .p(m_sn1));
   siu_mul #(.A_BITS(N), .B_BITS(N)) u_sn2  (.clock, .en, .a(s1y_ff), .b(acx_ff), .p(m_sn2));
   siu_mul #(.A_BITS(N), .B_BITS(N)) u_tn1  (.clock, .en, .a(s2x_ff), .b(acy_ff), .p(m_tn1));
   siu_mul #(.A_BITS(N), .B_BITS(N)) u_tn2  (.clock, .en, .a(s2y_ff), .b(acx_ff), .p(m_tn2));

   always_ff @(posedge clock) begin
      if (en) begin
         cs1x_ff[0] <= s1x_ff;
         cs1y_ff[0] <= s1y_ff;
         cax_ff[0]  <= ax0_ff;
         cay_ff[0]  <= ay0_ff;
         for (int i = 1; i <= MUL_LAT; i++) begin
            cs1x_ff[i] <= cs1x_ff[i-1];
            cs1y_ff[i] <= cs1y_ff[i-1];
            cax_ff[i]  <= cax_ff[i-1];
            cay_ff[i]  <= cay_ff[i-1];
         end
         den_ff <= D'(m_den1) - D'(m_den2);
         sn_ff  <= D'(m_sn1) - D'(m_sn2);
         tn_ff  <= D'(m_tn1) - D'(m_tn2);
      end
   end

   // fold the sign of the denominator into the numerators
   always_comb begin
      if (den_ff[D-1]) begin
         dabs_in = -den_ff;
         sadj_in = -sn_ff;
         tadj_in = -tn_ff;
      end else begin
         dabs_in = den_ff;
         sadj_in = sn_ff;
         tadj_in = tn_ff;
      end
      ok_in = (den_ff != '0) && !sadj_in[D-1] && (sadj_in <= dabs_in)
            && !tadj_in[D-1] && (tadj_in <= dabs_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dr_ff[0]   <= tadj_in;
         dd_ff[0]   <= dabs_in;
         dq_ff[0]   <= '0;
         dok_ff[0]  <= ok_in;
         ds1x_ff[0] <= cs1x_ff[MUL_LAT];
         ds1y_ff[0] <= cs1y_ff[MUL_LAT];
         dax_ff[0]  <= cax_ff[MUL_LAT];
         day_ff[0]  <= cay_ff[MUL_LAT];
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k <= T_FRAC; k++) begin : g_div
      logic [D-1:0] trial;
      logic         ge;
      assign ge    = dr_ff[k] >= dd_ff[k];
      assign trial = ge ? (dr_ff[k] - dd_ff[k]) : dr_ff[k];
      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[k+1]   <= trial << 1;
            dd_ff[k+1]   <= dd_ff[k];
            dq_ff[k+1]   <= dq_ff[k] | ((T_FRAC+1)'(ge) << (T_FRAC - k));
            dok_ff[k+1]  <= dok_ff[k];
            ds1x_ff[k+1] <= ds1x_ff[k];
            ds1y_ff[k+1] <= ds1y_ff[k];
            dax_ff[k+1]  <= dax_ff[k];
            day_ff[k+1]  <= day_ff[k];
         end
      end
   end

   assign t_val = $signed({1'b0, dq_ff[T_FRAC+1]});

   siu_mul #(.A_BITS(TA), .B_BITS(N)) u_px (.clock, .en, .a(t_val),
      .b(ds1x_ff[T_FRAC+1]), .p(m_px));
   siu_mul #(.A_BITS(TA), .B_BITS(N)) u_py (.clock, .en, .a(t_val),
      .b(ds1y_ff[T_FRAC+1]), .p(m_py));

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff[0]  <= dok_ff[T_FRAC+1];
         pax_ff[0] <= dax_ff[T_FRAC+1];
         pay_ff[0] <= day_ff[T_FRAC+1];
         for (int i = 1; i < MUL_LAT; i++) begin
            ok_ff[i]  <= ok_ff[i-1];
            pax_ff[i] <= pax_ff[i-1];
            pay_ff[i] <= pay_ff[i-1];
         end
         hit_ff <= ok_ff[MUL_LAT-1];
         cx_ff  <= ok_ff[MUL_LAT-1] ? pax_ff[MUL_LAT-1] + m_px[T_FRAC+W-1:T_FRAC] : '0;
         cy_ff  <= ok_ff[MUL_LAT-1] ? pay_ff[MUL_LAT-1] + m_py[T_FRAC+W-1:T_FRAC] : '0;
      end
   end

   assign rsp_valid   = v_ff[LAT-1];
   assign rsp_hit     = hit_ff;
   assign rsp_cross_x = cx_ff;
   assign rsp_cross_y = cy_ff;

   `SIU_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_cross_x == '0) && (rsp_cross_y == '0))
   `SIU_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, v_ff[0])
   `SIU_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(v_ff))
endmodule
`default_nettype wire
